// File: sv/sbte_pkg.sv
// Shared types, constants and the sextet-to-character mapping for the six-bit text encoder.
`timescale 1ns / 1ps

package sbte_pkg;

  localparam int MAX_RES     = 7;
  localparam int RES_IDX_W   = $clog2(MAX_RES);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  typedef struct packed {
    logic [MAX_RES-1:0][7:0] chars;
    logic [RES_IDX_W-1:0]    count;
  } cmd_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] c;
    if (v == 6'd62) begin
      c = 8'h2D;
    end else if (v == 6'd63) begin
      c = 8'h5F;
    end else if (v >= 6'd36) begin
      c = {2'b00, v} + 8'd61;
    end else if (v >= 6'd10) begin
      c = {2'b00, v} + 8'd55;
    end else begin
      c = {2'b00, v} + 8'd48;
    end
    return c;
  endfunction

endpackage

// File: sv/sbte_front.sv
// Front end: accepts byte beats, tracks held bits and column, and builds a character list.
`timescale 1ns / 1ps

module sbte_front
  import sbte_pkg::*;
#(
  parameter int LineChars = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [5:0] cfg_wr_data,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  input  logic       in_final,
  input  logic       q_full,
  output logic       in_ready,
  output logic       q_push,
  output cmd_t       q_cmd
);

  localparam int CW = ($clog2(LineChars + 1) > 7) ? $clog2(LineChars + 1) : 7;
  localparam logic [CW-1:0] LINE_LIM = CW'(LineChars);
  localparam int NTOK = 9;

  logic [4:0]    store_r, store_nxt;
  logic [2:0]    cnt_r, cnt_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [5:0]    start_r, start_nxt;

  logic [12:0]   w;
  logic [3:0]    total;
  logic          two;
  logic [3:0]    rem;
  logic [4:0]    rest;
  logic [CW-1:0] col1, col_a, col2, col_b;
  logic          crlf0, crlf1;
  logic          accept;

  logic [NTOK-1:0][7:0] tok;
  logic [NTOK-1:0]      tok_en;
  logic [3:0]           pos;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;

  assign w     = {8'd0, store_r} | ({5'd0, in_byte} << cnt_r);
  assign total = {1'b0, cnt_r} + 4'd8;
  assign two   = (total >= 4'd12);
  assign rem   = two ? (total - 4'd12) : (total - 4'd6);
  assign rest  = two ? {4'd0, w[12]} : w[10:6];

  assign col1  = col_r + CW'(1);
  assign crlf0 = (col1 >= LINE_LIM);
  assign col_a = crlf0 ? '0 : col1;
  assign col2  = col_a + CW'(1);
  assign crlf1 = (col2 >= LINE_LIM);
  assign col_b = crlf1 ? '0 : col2;

  always_comb begin
    tok[0] = sextet_char(w[5:0]);
    tok[1] = CHAR_CR;
    tok[2] = CHAR_LF;
    tok[3] = sextet_char(w[11:6]);
    tok[4] = CHAR_CR;
    tok[5] = CHAR_LF;
    tok[6] = sextet_char({1'b0, rest});
    tok[7] = CHAR_CR;
    tok[8] = CHAR_LF;
    tok_en[0] = 1'b1;
    tok_en[1] = crlf0;
    tok_en[2] = crlf0;
    tok_en[3] = two;
    tok_en[4] = two && crlf1;
    tok_en[5] = two && crlf1;
    tok_en[6] = in_final && (rem != 4'd0);
    tok_en[7] = in_final;
    tok_en[8] = in_final;
  end

  // Enabled tokens are packed in order; anything past the seventh is dropped.
  always_comb begin
    q_cmd.chars = '0;
    pos = 4'd0;
    for (int i = 0; i < NTOK; i++) begin
      if (tok_en[i] && (pos < 4'(MAX_RES))) begin
        q_cmd.chars[pos[RES_IDX_W-1:0]] = tok[i];
        pos = pos + 4'd1;
      end
    end
    q_cmd.count = pos[RES_IDX_W-1:0];
  end

  always_comb begin
    store_nxt = store_r;
    cnt_nxt   = cnt_r;
    col_nxt   = col_r;
    start_nxt = start_r;
    if (cfg_wr_en) begin
      start_nxt = cfg_wr_data;
      col_nxt   = CW'(cfg_wr_data);
    end else if (accept) begin
      if (in_final) begin
        store_nxt = '0;
        cnt_nxt   = '0;
        col_nxt   = CW'(start_r);
      end else begin
        store_nxt = rest;
        cnt_nxt   = rem[2:0];
        col_nxt   = two ? col_b : col_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r <= '0;
      cnt_r   <= '0;
      col_r   <= '0;
      start_r <= '0;
    end else begin
      store_r <= store_nxt;
      cnt_r   <= cnt_nxt;
      col_r   <= col_nxt;
      start_r <= start_nxt;
    end
  end

endmodule

// File: sv/sbte_queue.sv
// Two-entry command queue between the front end and the output sequencer.
`timescale 1ns / 1ps

module sbte_queue
  import sbte_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic valid,
  output cmd_t head
);

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   fill_r, fill_nxt;
  logic              do_push, do_pop;

  assign full    = (fill_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign valid   = (fill_r != '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + (QPTR_W + 1)'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - (QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

// File: sv/sbte_back.sv
// Output sequencer: sends the characters of each command, one per beat, flagging the last.
`timescale 1ns / 1ps

module sbte_back
  import sbte_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast
);

  cmd_t                 cur_r;
  logic [RES_IDX_W-1:0] idx_r, idx_nxt;
  logic                 busy_r, busy_nxt;
  logic                 fire, at_last, load;

  assign at_last    = (idx_r == cur_r.count - RES_IDX_W'(1));
  assign fire       = busy_r && out_tready;
  assign load       = q_valid && (!busy_r || (fire && at_last));
  assign q_pop      = load;
  assign out_tvalid = busy_r;
  assign out_tdata  = cur_r.chars[idx_r];
  assign out_tlast  = at_last;

  always_comb begin
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    if (load) begin
      idx_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (fire) begin
      if (at_last) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + RES_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= q_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      idx_r  <= idx_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

// File: sv/six_bit_text_encoder_core.sv
// Top level of the six-bit text encoder: front end, command queue and output sequencer.
`timescale 1ns / 1ps

// Encodes a byte stream, least significant bit first, into text over the alphabet 0-9, A-Z,
// a-z, '-', '_', with CR LF after every LineChars characters of a line and a closing CR LF
// after the beat marked tlast. An input beat is taken whenever the two-entry command queue
// has room; each byte then produces one to seven output beats, usually one or two, and the
// output sequencer sends one character per cycle while out_tready is high, so the sustained
// input rate is set by that one-character output. From an empty queue, an input beat's command
// is registered in the queue, then in the sequencer, before its first character is shown.
// cfg_wr_data sets the starting column; the user must write it only while the block is idle (not enforced).
module six_bit_text_encoder_core
  import sbte_pkg::*;
#(
  parameter int LineChars = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [5:0] cfg_wr_data,  // start_column
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,     // data_byte
  input  logic       in_tlast,     // is_final
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,    // out_char
  output logic       out_tlast     // out_last
);

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic q_push, q_full, q_valid, q_pop;

  sbte_front #(
    .LineChars(LineChars)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_tvalid),
    .in_byte    (in_tdata),
    .in_final   (in_tlast),
    .q_full     (q_full),
    .in_ready   (in_tready),
    .q_push     (q_push),
    .q_cmd      (front_cmd)
  );

  sbte_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(front_cmd),
    .pop     (q_pop),
    .full    (q_full),
    .valid   (q_valid),
    .head    (head_cmd)
  );

  sbte_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (head_cmd),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule

// File: sv/sbte_checker.sv
// Port-level checks for the six-bit text encoder and their binding to the top level.
`timescale 1ns / 1ps

module sbte_checker
  import sbte_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  logic out_legal;

  assign out_legal = (out_tdata >= 8'h30 && out_tdata <= 8'h39) ||
                     (out_tdata >= 8'h41 && out_tdata <= 8'h5A) ||
                     (out_tdata >= 8'h61 && out_tdata <= 8'h7A) ||
                     (out_tdata == 8'h2D) || (out_tdata == 8'h5F) ||
                     (out_tdata == CHAR_CR) || (out_tdata == CHAR_LF);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("Output beat changed while stalled.");

  a_legal_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_legal)
    else $error("Output character outside the alphabet.");

  a_cr_then_lf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tdata == CHAR_CR && !out_tlast
      |=> out_tvalid && out_tdata == CHAR_LF)
    else $error("CR not followed at once by LF.");

  a_first_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid || out_tdata != CHAR_LF)
    else $error("Line feed opened the results of a beat.");

endmodule

bind six_bit_text_encoder_core sbte_checker u_sbte_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast)
);

// File: verif/sbte_text_checker.sv
// Checker that predicts the encoded text of the six-bit text encoder and compares every output beat.
`timescale 1ns / 1ps

module sbte_text_checker
  import sbte_pkg::*;
#(
  parameter int LineChars = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [5:0]  cfg_wr_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic        out_tlast,
  output int unsigned fail_count,
  output int unsigned chars_pending
);

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_beat_t;

  text_beat_t  expected_text[$];
  logic [12:0] held_bits;
  logic [3:0]  held_count;
  int unsigned col;
  logic [5:0]  start_col;
  int unsigned mismatches = 0;

  function automatic logic [7:0] alphabet_char(input logic [5:0] s);
    logic [7:0] v;
    v = {2'b00, s};
    if (v < 8'd10) return "0" + v;
    if (v < 8'd36) return "A" + (v - 8'd10);
    if (v < 8'd62) return "a" + (v - 8'd36);
    if (v == 8'd62) return "-";
    return "_";
  endfunction

  function automatic void predict_text(input logic [7:0] b, input logic fin);
    logic [7:0] chars[$];
    text_beat_t beat;
    int         n;
    held_bits  = held_bits | (13'(b) << held_count);
    held_count = held_count + 4'd8;
    while (held_count >= 4'd6) begin
      chars.push_back(alphabet_char(held_bits[5:0]));
      held_bits  = held_bits >> 6;
      held_count = held_count - 4'd6;
      col++;
      if (col >= LineChars) begin
        col = 0;
        chars.push_back(CHAR_CR);
        chars.push_back(CHAR_LF);
      end
    end
    if (fin) begin
      if (held_count != 4'd0) chars.push_back(alphabet_char(held_bits[5:0]));
      chars.push_back(CHAR_CR);
      chars.push_back(CHAR_LF);
      held_bits  = '0;
      held_count = '0;
      col        = 32'(start_col);
    end
    n = (chars.size() > MAX_RES) ? MAX_RES : chars.size();
    for (int i = 0; i < n; i++) begin
      beat.ch   = chars[i];
      beat.last = (i == n - 1);
      expected_text.push_back(beat);
    end
  endfunction

  always @(posedge clk) begin
    text_beat_t exp_beat;
    if (!rst_n) begin
      held_bits  = '0;
      held_count = '0;
      start_col  = '0;
      col        = 0;
      expected_text.delete();
    end else begin
      if (cfg_wr_en) begin
        start_col = cfg_wr_data;
        col       = 32'(cfg_wr_data);
      end
      if (in_tvalid && in_tready) predict_text(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (expected_text.size() == 0) begin
          $error("out_char: expected nothing, actual %02h", out_tdata);
          mismatches++;
        end else begin
          exp_beat = expected_text.pop_front();
          if (out_tdata !== exp_beat.ch) begin
            $error("out_char: expected %02h, actual %02h", exp_beat.ch, out_tdata);
            mismatches++;
          end
          if (out_tlast !== exp_beat.last) begin
            $error("out_last: expected %0b, actual %0b", exp_beat.last, out_tlast);
            mismatches++;
          end
        end
      end
    end
    chars_pending <= expected_text.size();
    fail_count    <= mismatches;
  end

endmodule

// File: verif/tb_six_bit_text_encoder_core.sv
// Testbench top for the six-bit text encoder: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_six_bit_text_encoder_core;

  localparam int LINE_LEN   = 64;
  localparam int LONG_HOLD  = 300;
  localparam int RAND_ITEMS = 280;
  localparam int NUM_PHASES = 6;

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       cfg_wr_en   = 1'b0;
  logic [5:0] cfg_wr_data = '0;
  logic       in_tvalid   = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata    = '0;
  logic       in_tlast    = 1'b0;
  logic       out_tvalid;
  logic       out_tready  = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;

  int unsigned fail_count;
  int unsigned chars_pending;

  bit tx_full_speed = 1'b0;
  bit rx_full_speed = 1'b0;
  bit hold_off_req  = 1'b0;

  six_bit_text_encoder_core #(
    .LineChars(LINE_LEN)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  sbte_text_checker #(
    .LineChars(LINE_LEN)
  ) watcher (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .fail_count   (fail_count),
    .chars_pending(chars_pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin : watchdog
    #12_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic int unsigned idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
  endfunction

  initial begin : receiver
    forever begin
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (!rx_full_speed && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    gap = (!tx_full_speed && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_text_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_start_column(input logic [5:0] c);
    wait_text_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= c;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned phase_sent;
    int unsigned len;
    logic [5:0]  col_setting;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: byte extremes, exact sextet fill, leftover flushes and early line breaks.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte(8'hAA, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    set_start_column(6'd63);
    send_byte(8'h3C, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);
    set_start_column(6'd60);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h3C, 1'b1);
    set_start_column(6'd0);
    send_byte(8'h00, 1'b1);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      col_setting = (phase == 0) ? 6'd0 : (phase == 1) ? 6'd63 : 6'($urandom);
      set_start_column(col_setting);
      tx_full_speed = (phase == 2) || (phase == 3);
      rx_full_speed = (phase == 2);
      if (phase == 3) hold_off_req = 1'b1;
      phase_sent = 0;
      while (phase_sent < RAND_ITEMS / NUM_PHASES) begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 12);
        if (len > RAND_ITEMS / NUM_PHASES - phase_sent) begin
          len = RAND_ITEMS / NUM_PHASES - phase_sent;
        end
        for (int i = 0; i < len; i++) begin
          send_byte(8'($urandom), i == len - 1);
        end
        phase_sent += len;
        if ($urandom_range(0, 7) == 0) wait_text_drained();
      end
    end

    rx_full_speed = 1'b1;
    wait_text_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && chars_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
